// ===== rtl/packed_shadow_bits_3x3_blur_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packed shadow blur
// Shared wrappers around concurrent assertions clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_SHADOW_BITS_3X3_BLUR_ASSERT_SVH
`define PACKED_SHADOW_BITS_3X3_BLUR_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PSB_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("packed shadow blur check failed");

// A condition that must hold in the cycle after a trigger.
`define PSB_CHECK_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("packed shadow blur sequence check failed");

`endif

// ===== rtl/psb_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed shadow blur package
// Sizes, configuration register codes and types shared by the blur modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psb_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int LINE_BYTES = (MAX_WIDTH + 7) / 8;
  localparam int COL_W      = $clog2(LINE_BYTES);
  localparam int CFG_W      = 10;
  localparam int ROW_W      = 10;
  localparam int PIX_W      = 5;
  localparam int LANES      = 8;

  localparam logic [CFG_W-1:0] MAX_WIDTH_CFG  = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] MAX_HEIGHT_CFG = CFG_W'(MAX_HEIGHT);
  localparam logic [CFG_W-1:0] RESET_WIDTH    = CFG_W'(128);
  localparam logic [CFG_W-1:0] RESET_HEIGHT   = CFG_W'(128);

  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  // Column triple: above row in [23:16], center row in [15:8], below row in [7:0].
  typedef logic [23:0] trip_t;
  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [LANES-1:0] pix_row_t;

  typedef struct packed {
    logic [3:0] count;
    logic       first_col;
    logic       last_col;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/psb_lanes.sv =====
// ----------------------------------------------------------------------------
// Blur lanes
// Eight parallel 1-2-1 by 1-2-1 kernel lanes over one byte column of a window.
// ----------------------------------------------------------------------------
`default_nettype none

module psb_lanes (
  input  wire psb_pkg::trip_t    prev,
  input  wire psb_pkg::trip_t    cur,
  input  wire psb_pkg::trip_t    nxt,
  input  wire psb_pkg::lane_ctl_t ctl,
  output psb_pkg::pix_row_t      pix
);

  logic [2:0][23:0] vec;
  logic [psb_pkg::LANES-1:0][2:0][2:0] hs;

  genvar i, k;
  generate
    for (k = 0; k < 3; k++) begin : g_row
      assign vec[k] = {nxt[8*k+7:8*k], cur[8*k+7:8*k], prev[8*k+7:8*k]};
    end

    for (i = 0; i < psb_pkg::LANES; i++) begin : g_lane
      logic [psb_pkg::PIX_W-1:0] sum;
      for (k = 0; k < 3; k++) begin : g_tap
        logic lft, mid, rgt;
        assign lft = (ctl.first_col && (i == 0)) ? vec[k][8] : vec[k][7+i];
        assign mid = vec[k][8+i];
        assign rgt = (ctl.last_col && (ctl.count == 4'(i + 1))) ? vec[k][8+i] : vec[k][9+i];
        assign hs[i][k] = {2'b00, lft} + {1'b0, mid, 1'b0} + {2'b00, rgt};
      end
      assign sum = {2'b00, hs[i][2]} + {1'b0, hs[i][1], 1'b0} + {2'b00, hs[i][0]};
      assign pix[i] = (4'(i) < ctl.count) ? sum : '0;
    end
  endgenerate

endmodule

`default_nettype wire

// ===== rtl/packed_shadow_bits_3x3_blur.sv =====
// ----------------------------------------------------------------------------
// Packed shadow bits 3x3 blur
// Binomial 3x3 blur of a packed 1-bit shadow map with clamped edges.
// ----------------------------------------------------------------------------
// The block takes one packed byte per cycle and, when its output is not
// stalled, sustains one request per cycle with no bubbles. The request that
// completes a window is held in the stage-1 registers, and its result is then
// captured in the output register: the line memories are read at the
// accepting edge, and the eight kernel lanes work on that data from stage 1
// into the output register. The rate is set by the single read and
// single write of each line memory per request; back-to-back requests on the
// same entry (a one-byte row) are forwarded. Results lag the input by one row
// and one byte, so a frame needs pitch plus one flush requests after its data.
// No clearing pass runs after reset; the line memories are valid only once
// written by the first rows.
`default_nettype none

`include "packed_shadow_bits_3x3_blur_assert.svh"

module packed_shadow_bits_3x3_blur (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_write,
  input  wire  [0:0]                   cfg_index,
  input  wire  [psb_pkg::CFG_W-1:0]    cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          mode,
  input  wire  [7:0]                   packed_bits,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [psb_pkg::PIX_W-1:0]    pixel_0,
  output logic [psb_pkg::PIX_W-1:0]    pixel_1,
  output logic [psb_pkg::PIX_W-1:0]    pixel_2,
  output logic [psb_pkg::PIX_W-1:0]    pixel_3,
  output logic [psb_pkg::PIX_W-1:0]    pixel_4,
  output logic [psb_pkg::PIX_W-1:0]    pixel_5,
  output logic [psb_pkg::PIX_W-1:0]    pixel_6,
  output logic [psb_pkg::PIX_W-1:0]    pixel_7,
  output logic [8:0]                   out_row,
  output logic [5:0]                   out_byte_column,
  output logic                         last_of_frame
);

  localparam int COL_W = psb_pkg::COL_W;
  localparam int ROW_W = psb_pkg::ROW_W;
  localparam int CFG_W = psb_pkg::CFG_W;

  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;
  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;

  logic [7:0] mem_above  [psb_pkg::LINE_BYTES];
  logic [7:0] mem_center [psb_pkg::LINE_BYTES];
  logic [7:0] rd_above;
  logic [7:0] rd_center;

  logic             s1_valid;
  logic             s1_has_out;
  logic             s1_flush;
  logic             s1_top;
  logic             s1_fwd;
  logic             s1_last;
  logic [7:0]       s1_data;
  logic [COL_W-1:0] s1_addr;
  logic [8:0]       s1_row;
  logic [5:0]       s1_col;
  psb_pkg::lane_ctl_t s1_ctl;

  logic [COL_W-1:0] wr_addr;
  logic [7:0]       wr_ctr;
  logic [7:0]       wr_blw;

  psb_pkg::trip_t win_cur;
  psb_pkg::trip_t win_prev;

  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [CFG_W:0]   pitch_sum;
  logic [COL_W:0]   pitch;
  logic [COL_W:0]   pitch_m1;
  logic [COL_W:0]   col_inc;
  logic [3:0]       last_count;
  logic             c_nz;
  logic [ROW_W-1:0] ro;
  logic [5:0]       co;
  logic             ro_ok;
  logic             is_last_col;
  logic             acc_last;
  logic             acc_flush;
  logic             accept;
  logic             out_free;
  logic             s1_adv;

  logic [7:0]       ctr;
  logic [7:0]       abv_mem;
  logic [7:0]       abv;
  logic [7:0]       blw;
  psb_pkg::trip_t   triple;
  psb_pkg::pix_row_t pix;

  always_comb begin
    if (map_width == '0) begin
      w_eff = CFG_W'(1);
    end else if (map_width > psb_pkg::MAX_WIDTH_CFG) begin
      w_eff = psb_pkg::MAX_WIDTH_CFG;
    end else begin
      w_eff = map_width;
    end
    if (map_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (map_height > psb_pkg::MAX_HEIGHT_CFG) begin
      h_eff = psb_pkg::MAX_HEIGHT_CFG;
    end else begin
      h_eff = map_height;
    end
  end

  assign pitch_sum  = {1'b0, w_eff} + (CFG_W+1)'(7);
  assign pitch      = pitch_sum[COL_W+3:3];
  assign pitch_m1   = pitch - (COL_W+1)'(1);
  assign last_count = (w_eff[2:0] == 3'd0) ? 4'd8 : {1'b0, w_eff[2:0]};
  assign col_inc    = {1'b0, in_column} + (COL_W+1)'(1);

  assign c_nz        = (in_column != '0);
  assign ro          = c_nz ? (in_row - ROW_W'(1)) : (in_row - ROW_W'(2));
  assign co          = c_nz ? 6'(in_column - COL_W'(1)) : 6'(pitch_m1);
  assign ro_ok       = (c_nz ? (in_row >= ROW_W'(1)) : (in_row >= ROW_W'(2))) &&
                       (ro < h_eff);
  assign is_last_col = ((COL_W+1)'(co) == pitch_m1);
  assign acc_last    = ro_ok && (ro == (h_eff - CFG_W'(1))) && is_last_col;
  assign acc_flush   = mode || (in_row >= h_eff);

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && (!s1_has_out || out_free);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign ctr     = s1_fwd ? wr_blw : rd_center;
  assign abv_mem = s1_fwd ? wr_ctr : rd_above;
  assign abv     = s1_top ? ctr : abv_mem;
  assign blw     = s1_flush ? ctr : s1_data;
  assign triple  = {abv, ctr, blw};

  psb_lanes u_lanes (
    .prev (win_prev),
    .cur  (win_cur),
    .nxt  (triple),
    .ctl  (s1_ctl),
    .pix  (pix)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem_above[s1_addr]  <= ctr;
      mem_center[s1_addr] <= blw;
    end
    if (accept) begin
      rd_above  <= mem_above[in_column];
      rd_center <= mem_center[in_column];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= psb_pkg::RESET_WIDTH;
      map_height <= psb_pkg::RESET_HEIGHT;
      in_column  <= '0;
      in_row     <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      win_cur    <= '0;
      win_prev   <= '0;
    end else begin
      if (accept) begin
        if (acc_last) begin
          in_column <= '0;
          in_row    <= '0;
        end else if (col_inc >= pitch) begin
          in_column <= '0;
          in_row    <= in_row + ROW_W'(1);
        end else begin
          in_column <= col_inc[COL_W-1:0];
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_last) begin
          win_cur  <= '0;
          win_prev <= '0;
        end else begin
          win_cur  <= triple;
          win_prev <= win_cur;
        end
      end
      if (s1_adv && s1_has_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (psb_pkg::cfg_reg_t'(cfg_index))
          psb_pkg::REG_MAP_WIDTH: begin
            map_width <= cfg_data;
          end
          psb_pkg::REG_MAP_HEIGHT: begin
            map_height <= cfg_data;
          end
        endcase
        in_column <= '0;
        in_row    <= '0;
        win_cur   <= '0;
        win_prev  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_has_out          <= ro_ok;
      s1_flush            <= acc_flush;
      s1_top              <= (in_row == ROW_W'(1));
      s1_fwd              <= s1_adv && (s1_addr == in_column);
      s1_last             <= acc_last;
      s1_data             <= packed_bits;
      s1_addr             <= in_column;
      s1_row              <= ro[8:0];
      s1_col              <= co;
      s1_ctl.count        <= is_last_col ? last_count : 4'd8;
      s1_ctl.first_col    <= (co == 6'd0);
      s1_ctl.last_col     <= is_last_col;
    end
    if (s1_adv) begin
      wr_addr <= s1_addr;
      wr_ctr  <= ctr;
      wr_blw  <= blw;
    end
    if (s1_adv && s1_has_out) begin
      pixel_0         <= pix[0];
      pixel_1         <= pix[1];
      pixel_2         <= pix[2];
      pixel_3         <= pix[3];
      pixel_4         <= pix[4];
      pixel_5         <= pix[5];
      pixel_6         <= pix[6];
      pixel_7         <= pix[7];
      out_row         <= s1_row;
      out_byte_column <= s1_col;
      last_of_frame   <= s1_last;
    end
  end

  `PSB_CHECK(a_fwd_addr, (s1_valid && s1_fwd) |-> (wr_addr == s1_addr))
  `PSB_CHECK_NEXT(a_frame_restart, accept && acc_last, in_column == '0 && in_row == '0)
  `PSB_CHECK(a_stall_cause, in_stall |-> (s1_has_out && out_valid && out_stall))

endmodule

`default_nettype wire

// ===== sim/packed_shadow_bits_3x3_blur_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the packed shadow bits 3x3 blur
// Streams packed shadow map frames of many sizes through the block with random
// gaps and output stalls. A predictor keeps its own line buffers and window,
// works out the blurred byte column each request causes, and checks every
// result against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_shadow_bits_3x3_blur_tb;

  typedef struct packed {
    psb_pkg::pix_row_t px;
    logic [8:0]        row;
    logic [5:0]        col;
    logic              last;
  } blur_col_t;

  class blur_model;
    logic [psb_pkg::CFG_W-1:0] width_reg;
    logic [psb_pkg::CFG_W-1:0] height_reg;
    logic [7:0]       above_line [psb_pkg::LINE_BYTES];
    logic [7:0]       center_line [psb_pkg::LINE_BYTES];
    bit               center_written [psb_pkg::LINE_BYTES];
    logic [23:0]      win_prev;
    logic [23:0]      win_cur;
    int               cur_row;
    int               cur_col;
    blur_col_t        blurred_q [$];
    int               errors;

    function new();
      width_reg  = psb_pkg::RESET_WIDTH;
      height_reg = psb_pkg::RESET_HEIGHT;
      for (int i = 0; i < psb_pkg::LINE_BYTES; i++) begin
        above_line[i]     = 8'h00;
        center_line[i]    = 8'h00;
        center_written[i] = 1'b0;
      end
      errors = 0;
      restart();
    endfunction

    function void restart();
      cur_row  = 0;
      cur_col  = 0;
      win_prev = '0;
      win_cur  = '0;
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > psb_pkg::MAX_WIDTH) return psb_pkg::MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > psb_pkg::MAX_HEIGHT) return psb_pkg::MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    function void write_reg(psb_pkg::cfg_reg_t idx, logic [psb_pkg::CFG_W-1:0] val);
      if (idx == psb_pkg::REG_MAP_WIDTH) width_reg = val;
      else height_reg = val;
      restart();
    endfunction

    function int pick(logic [23:0] pv, logic [23:0] cu, logic [23:0] nx, int s, int x,
                      int base);
      logic [23:0] vec;
      int          bi;
      vec = {nx[s+:8], cu[s+:8], pv[s+:8]};
      bi  = x - base + 8;
      if (bi < 0 || bi > 23) return 0;
      return int'(vec[bi]);
    endfunction

    // Returns 1 when the request completes the frame.
    function bit accept_byte(logic m, logic [7:0] b);
      int          w, h, pitch, r, c, ro, co, base, x, xl, xr, sum, hs, wr, s;
      logic [7:0]  ctr, abv, blw;
      logic [23:0] trip;
      bit          flush, last;
      blur_col_t   res;
      w     = eff_width();
      h     = eff_height();
      pitch = (w + 7) / 8;
      r     = cur_row;
      c     = cur_col;
      flush = m || (r >= h);
      ctr   = center_line[c];
      abv   = (r == 1) ? ctr : above_line[c];
      blw   = flush ? ctr : b;
      trip  = {abv, ctr, blw};
      last  = 1'b0;
      if (c >= 1) begin
        ro = r - 1;
        co = c - 1;
      end else begin
        ro = r - 2;
        co = pitch - 1;
      end
      if (ro >= 0 && ro < h) begin
        base = co * 8;
        for (int i = 0; i < psb_pkg::LANES; i++) begin
          x   = base + i;
          sum = 0;
          if (x < w) begin
            for (int k = 0; k < 3; k++) begin
              s   = 16 - 8 * k;
              wr  = (k == 1) ? 2 : 1;
              xl  = (x - 1 < 0) ? 0 : x - 1;
              xr  = (x + 1 > w - 1) ? w - 1 : x + 1;
              hs  = pick(win_prev, win_cur, trip, s, xl, base) +
                    2 * pick(win_prev, win_cur, trip, s, x, base) +
                    pick(win_prev, win_cur, trip, s, xr, base);
              sum += wr * hs;
            end
          end
          res.px[i] = psb_pkg::pix_t'(sum);
        end
        last     = (ro == h - 1) && (co == pitch - 1);
        res.row  = 9'(ro);
        res.col  = 6'(co);
        res.last = last;
        blurred_q.push_back(res);
      end
      win_prev          = win_cur;
      win_cur           = trip;
      above_line[c]     = ctr;
      center_line[c]    = blw;
      center_written[c] = 1'b1;
      c++;
      if (c >= pitch) begin
        c = 0;
        r++;
      end
      cur_col = c;
      cur_row = r & 10'h3FF;
      if (last) restart();
      return last;
    endfunction

    function void match_column(blur_col_t got);
      blur_col_t want;
      if (blurred_q.size() == 0) begin
        $error("unexpected result at row %0d byte column %0d", got.row, got.col);
        errors++;
        return;
      end
      want = blurred_q.pop_front();
      for (int i = 0; i < psb_pkg::LANES; i++) begin
        if (got.px[i] !== want.px[i]) begin
          $error("pixel_%0d expected %0d got %0d", i, want.px[i], got.px[i]);
          errors++;
        end
      end
      if (got.row !== want.row) begin
        $error("out_row expected %0d got %0d", want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("out_byte_column expected %0d got %0d", want.col, got.col);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_frame expected %0d got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write;
  logic [0:0]                cfg_index;
  logic [psb_pkg::CFG_W-1:0] cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      mode;
  logic [7:0]                packed_bits;
  logic                      out_valid;
  logic                      out_stall;
  psb_pkg::pix_t             pixel_0, pixel_1, pixel_2, pixel_3;
  psb_pkg::pix_t             pixel_4, pixel_5, pixel_6, pixel_7;
  logic [8:0]                out_row;
  logic [5:0]                out_byte_column;
  logic                      last_of_frame;

  blur_model bm;
  int        in_gap_max;
  int        out_gap_max;
  int        item_count;

  packed_shadow_bits_3x3_blur u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .packed_bits    (packed_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_0        (pixel_0),
    .pixel_1        (pixel_1),
    .pixel_2        (pixel_2),
    .pixel_3        (pixel_3),
    .pixel_4        (pixel_4),
    .pixel_5        (pixel_5),
    .pixel_6        (pixel_6),
    .pixel_7        (pixel_7),
    .out_row        (out_row),
    .out_byte_column(out_byte_column),
    .last_of_frame  (last_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic write_reg(input psb_pkg::cfg_reg_t idx,
                           input logic [psb_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    bm.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_map(input logic [psb_pkg::CFG_W-1:0] w,
                         input logic [psb_pkg::CFG_W-1:0] h);
    write_reg(psb_pkg::REG_MAP_WIDTH, w);
    write_reg(psb_pkg::REG_MAP_HEIGHT, h);
  endtask

  task automatic send_item(input logic m, input logic [7:0] b, output bit done);
    int gap;
    gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    packed_bits <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    done = bm.accept_byte(m, b);
  endtask

  // Waits until every expected result has left the block, then lets the
  // pipeline empty of requests that cause no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (bm.blurred_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drives one frame; a nonzero cut stops it early after that many requests.
  // The frame also stops once the run has sent its share of requests.
  task automatic drive_frame(input int cut);
    int         n;
    bit         done;
    logic       m;
    logic [7:0] b;
    n    = 0;
    done = 1'b0;
    while (!done && (cut == 0 || n < cut) && item_count < 800) begin
      if (bm.cur_row >= bm.eff_height()) m = ($urandom_range(0, 3) != 0);
      else if (bm.cur_row == 0 && !bm.center_written[bm.cur_col]) m = 1'b0;
      else m = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else b = 8'($urandom);
      send_item(m, b, done);
      n++;
      item_count++;
    end
  endtask

  task automatic directed_frames();
    bit done;
    set_map(10'd9, 10'd2);
    send_item(1'b0, 8'hFF, done);
    send_item(1'b0, 8'h01, done);
    send_item(1'b0, 8'h80, done);
    send_item(1'b1, 8'h3C, done);
    send_item(1'b0, 8'hA5, done);
    send_item(1'b1, 8'h00, done);
    send_item(1'b1, 8'hFF, done);
    settle();
    set_map(10'd1, 10'd1);
    send_item(1'b0, 8'h01, done);
    send_item(1'b1, 8'hFE, done);
    send_item(1'b1, 8'h00, done);
    settle();
    set_map(10'd16, 10'd1);
    send_item(1'b0, 8'h00, done);
    send_item(1'b0, 8'hFF, done);
    send_item(1'b1, 8'h5A, done);
    send_item(1'b0, 8'hFF, done);
    send_item(1'b1, 8'h00, done);
    settle();
  endtask

  task automatic random_phase();
    int                        frames;
    int                        w;
    int                        h;
    int                        pitch;
    logic [psb_pkg::CFG_W-1:0] wv;
    logic [psb_pkg::CFG_W-1:0] hv;
    case ($urandom_range(0, 9))
      0: wv = 10'd0;
      1: wv = $urandom_range(0, 1) ? 10'd1023 : 10'd512;
      2: wv = 10'($urandom_range(41, 1023));
      default: wv = 10'($urandom_range(1, 40));
    endcase
    if (wv > 10'd64) hv = 10'($urandom_range(0, 3));
    else if ($urandom_range(0, 9) == 0) hv = 10'd0;
    else hv = 10'($urandom_range(1, 8));
    case ($urandom_range(0, 9))
      0: write_reg(psb_pkg::REG_MAP_WIDTH, wv);
      1: write_reg(psb_pkg::REG_MAP_HEIGHT, hv);
      default: set_map(wv, hv);
    endcase
    in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 9;
    out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
    w      = bm.eff_width();
    h      = bm.eff_height();
    pitch  = (w + 7) / 8;
    frames = $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      if (f == frames - 1 && $urandom_range(0, 4) == 0)
        drive_frame($urandom_range(1, (h + 1) * pitch));
      else
        drive_frame(0);
    end
    settle();
  endtask

  initial begin
    blur_col_t got;
    out_stall = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      int gap;
      gap = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.px[0] = pixel_0;
      got.px[1] = pixel_1;
      got.px[2] = pixel_2;
      got.px[3] = pixel_3;
      got.px[4] = pixel_4;
      got.px[5] = pixel_5;
      got.px[6] = pixel_6;
      got.px[7] = pixel_7;
      got.row   = out_row;
      got.col   = out_byte_column;
      got.last  = last_of_frame;
      bm.match_column(got);
    end
  end

  initial begin
    bm          = new();
    cfg_write   = 1'b0;
    cfg_index   = psb_pkg::REG_MAP_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    mode        = 1'b0;
    packed_bits = 8'h00;
    in_gap_max  = 9;
    out_gap_max = 9;
    item_count  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_frames();
    set_map(10'd1023, 10'd1);
    drive_frame(0);
    settle();
    set_map(10'd0, 10'd0);
    drive_frame(0);
    settle();
    set_map(10'd7, 10'd1023);
    drive_frame(0);
    settle();
    while (item_count < 800) random_phase();
    settle();
    repeat (10) @(posedge clk);
    if (bm.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/psb_pkg.sv
rtl/psb_lanes.sv
rtl/packed_shadow_bits_3x3_blur.sv
sim/packed_shadow_bits_3x3_blur_tb.sv
